### hw/rtl/sorted_priority_queue_macros.svh
// Assertion macros for the sorted priority queue checker
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// check post in the cycle after pre
`define SPQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sorted_priority_queue: next-cycle check failed");

// check post in the same cycle as pre
`define SPQ_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sorted_priority_queue: same-cycle check failed");

`endif

### hw/rtl/spq_pkg.sv
// Package: types and constants shared by the sorted priority queue
`timescale 1ns / 1ps
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] item_value;
        logic        [15:0] item_priority;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic        [1:0]  status;
        logic        [4:0]  fill_count;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

endpackage

### hw/rtl/sorted_priority_queue.sv
// Top level: sorted priority queue, controller plus slot datapath
// done is registered in the execute state that the accepting start edge enters; result is valid while done is high.
// A new item is taken only in idle, after the execute state; busy is high for the one execute cycle.
// The execute cycle compares all slots in parallel and inserts or shifts at once.
// Reset (rst_n, asynchronous, active low) empties the queue; slot contents are not cleared.
// Results cannot be stalled: each is shown for one cycle on done.
`timescale 1ns / 1ps
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      done,
    output out_item_t result
);

    dp_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    spq_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule

### hw/rtl/spq_ctrl.sv
// Controller: sequences capture and commit of one item at a time
`timescale 1ns / 1ps
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output logic    done,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;
    logic        done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        busy        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                busy       = 1'b1;
                cmd.commit = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done = done_reg;

endmodule

### hw/rtl/spq_datapath.sv
// Datapath: sorted slot registers, parallel insert and shift, result register
`timescale 1ns / 1ps
module spq_datapath
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_cmd_t   cmd,
    input  in_item_t  item,
    output out_item_t result
);

    in_item_t           item_reg;
    out_item_t          result_reg;
    logic signed [31:0] val_reg  [DEPTH];
    logic        [15:0] prio_reg [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic [DEPTH-1:0]   gt;
    logic [DEPTH-1:0]   ins;
    logic               is_deq;
    logic               full;
    logic               empty;
    logic               do_enq;
    logic               do_deq;

    assign is_deq = (item_reg.opcode == OP_DEQUEUE);
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_enq = !is_deq && !full;
    assign do_deq = is_deq && !empty;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (CNT_W'(i) < count_reg) && (item_reg.item_priority < prio_reg[i]);
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            ins[i] = (CNT_W'(i) == count_reg) || gt[i];
            if (i > 0)
            begin
                ins[i] = ins[i] && !gt[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.commit)
        begin
            result_reg.fill_count <= 5'(count_next);
            if (is_deq)
            begin
                result_reg.out_value <= empty ? 32'sd0 : val_reg[0];
                result_reg.status    <= empty ? ST_EMPTY : ST_DONE;
            end
            else
            begin
                result_reg.out_value <= 32'sd0;
                result_reg.status    <= full ? ST_FULL : ST_DONE;
            end
        end
    end

    // enqueue: insert at the sorted place, moving later slots back; dequeue: advance toward the front
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cmd.commit && do_enq)
            begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                begin
                    val_reg[i]  <= val_reg[(i > 0) ? i - 1 : 0];
                    prio_reg[i] <= prio_reg[(i > 0) ? i - 1 : 0];
                end
                else if (ins[i])
                begin
                    val_reg[i]  <= item_reg.item_value;
                    prio_reg[i] <= item_reg.item_priority;
                end
            end
            else if (cmd.commit && do_deq && i < DEPTH - 1)
            begin
                val_reg[i]  <= val_reg[(i < DEPTH - 1) ? i + 1 : i];
                prio_reg[i] <= prio_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    assign result = result_reg;

endmodule

### hw/rtl/spq_checker.sv
// Checker: port-level assertions for the sorted priority queue, bound to the top level
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"
module spq_checker
    import spq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_item_t result
);

    logic full_shape;
    logic empty_shape;

    assign full_shape  = (result.fill_count == 5'(DEPTH)) && (result.out_value == 32'sd0);
    assign empty_shape = (result.fill_count == 5'd0) && (result.out_value == 32'sd0);

    `SPQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `SPQ_ASSERT_NEXT(a_busy_one_cycle, clk, rst_n, busy, !busy && done)
    `SPQ_ASSERT_NEXT(a_done_needs_item, clk, rst_n, !busy, !done)
    `SPQ_ASSERT_SAME(a_full_count, clk, rst_n, done && result.status == ST_FULL, full_shape)
    `SPQ_ASSERT_SAME(a_empty_count, clk, rst_n, done && result.status == ST_EMPTY, empty_shape)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### dv/tb.sv
// Testbench for sorted_priority_queue: directed table, random traffic, self-checking predictor
`timescale 1ns / 1ps
module tb;
    import spq_pkg::*;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } drow_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_item_t  item;
    logic      busy;
    logic      done;
    out_item_t result;

    logic signed [31:0] held_vals  [DEPTH];
    logic        [15:0] held_prios [DEPTH];
    int                 held;

    out_item_t pending_outcomes [$];
    out_item_t awaited;
    drow_t     directed [$];
    int        faults;
    int        idle_pct;
    int        enq_bias;

    sorted_priority_queue u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #4 clk = ~clk;

    function automatic out_item_t serve_op(input in_item_t it);
        out_item_t res;
        int        slot;
        res = '0;
        if (it.opcode == OP_DEQUEUE)
        begin
            if (held == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.out_value = held_vals[0];
                for (slot = 1; slot < held; slot++)
                begin
                    held_vals[slot - 1]  = held_vals[slot];
                    held_prios[slot - 1] = held_prios[slot];
                end
                held--;
                res.status = ST_DONE;
            end
        end
        else if (held >= DEPTH)
        begin
            res.status = ST_FULL;
        end
        else
        begin
            slot = held;
            while (slot > 0 && it.item_priority < held_prios[slot - 1])
            begin
                held_vals[slot]  = held_vals[slot - 1];
                held_prios[slot] = held_prios[slot - 1];
                slot--;
            end
            held_vals[slot]  = it.item_value;
            held_prios[slot] = it.item_priority;
            held++;
            res.status = ST_DONE;
        end
        res.fill_count = 5'(held);
        return res;
    endfunction

    function automatic in_item_t random_item(input int enq_pct);
        in_item_t    it;
        int unsigned r;
        it.opcode     = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
        it.item_value = $urandom;
        if ($urandom_range(0, 9) == 0)
            it.item_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        r = $urandom_range(0, 9);
        if (r < 5)
            it.item_priority = 16'($urandom_range(0, 3));
        else if (r < 7)
            it.item_priority = r[0] ? 16'hFFFF : 16'h0000;
        else
            it.item_priority = 16'($urandom);
        return it;
    endfunction

    function automatic void add_row(input opcode_t op, input logic [31:0] val,
                                    input logic [15:0] prio, input bit typed,
                                    input logic [31:0] wval, input status_t wst,
                                    input logic [4:0] wfill);
        drow_t row;
        row.stim.opcode        = op;
        row.stim.item_value    = val;
        row.stim.item_priority = prio;
        row.typed              = typed;
        row.want.out_value     = wval;
        row.want.status        = wst;
        row.want.fill_count    = wfill;
        directed.push_back(row);
    endfunction

    task automatic note_fault(input string what, input out_item_t want, input out_item_t got);
        faults++;
        if (faults <= 10)
            $display("%0t %s: expected value %h status %0d fill %0d, got value %h status %0d fill %0d",
                     $time, what, want.out_value, want.status, want.fill_count,
                     got.out_value, got.status, got.fill_count);
    endtask

    task automatic issue(input in_item_t it, input bit typed, input out_item_t want,
                         input int gap_pct);
        out_item_t predicted;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = serve_op(it);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                note_fault("unexpected result", '0, result);
            end
            else
            begin
                awaited = pending_outcomes.pop_front();
                if (awaited.out_value !== result.out_value)
                    note_fault("out_value mismatch", awaited, result);
                if (awaited.status !== result.status)
                    note_fault("status mismatch", awaited, result);
                if (awaited.fill_count !== result.fill_count)
                    note_fault("fill_count mismatch", awaited, result);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [15:0] fill_prio [16];
        logic [31:0] fill_val;

        clk    = 1'b0;
        rst_n  = 1'b0;
        start  = 1'b0;
        item   = '0;
        faults = 0;
        held   = 0;
        fill_prio = '{16'd5, 16'd3, 16'd5, 16'd0, 16'd3, 16'hFFFF, 16'd5, 16'd1,
                      16'd0, 16'd3, 16'd7, 16'd7, 16'hFFFF, 16'd2, 16'd5, 16'd0};

        add_row(OP_DEQUEUE, 32'h0, 16'h0, 1'b1, 32'h0, ST_EMPTY, 5'd0);
        add_row(OP_ENQUEUE, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 32'h0, ST_DONE, 5'd1);
        add_row(OP_ENQUEUE, 32'h8000_0000, 16'h0000, 1'b1, 32'h0, ST_DONE, 5'd2);
        add_row(OP_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'h8000_0000, ST_DONE, 5'd1);
        add_row(OP_DEQUEUE, 32'h0, 16'h0, 1'b1, 32'h7FFF_FFFF, ST_DONE, 5'd0);
        add_row(OP_DEQUEUE, 32'h0, 16'h0, 1'b1, 32'h0, ST_EMPTY, 5'd0);
        for (int i = 0; i < 16; i++)
        begin
            fill_val = (32'(i) * 32'h0101_0101) ^ (i[0] ? 32'hFFFF_0000 : 32'h0);
            add_row(OP_ENQUEUE, fill_val, fill_prio[i], 1'b0, 32'h0, ST_DONE, 5'd0);
        end
        add_row(OP_ENQUEUE, 32'h1234_5678, 16'h0000, 1'b1, 32'h0, ST_FULL, 5'd16);
        add_row(OP_DEQUEUE, 32'h0, 16'h0, 1'b0, 32'h0, ST_DONE, 5'd0);
        add_row(OP_ENQUEUE, 32'hCAFE_0001, 16'd3, 1'b0, 32'h0, ST_DONE, 5'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            issue(directed[i].stim, directed[i].typed, directed[i].want, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 15 : (ph == 1) ? 64 : 0;
            for (int n = 0; n < 610; n++)
            begin
                if (n % 40 == 0)
                    enq_bias = 25 + 27 * $urandom_range(0, 2);
                issue(random_item(enq_bias), 1'b0, '0, idle_pct);
            end
            start <= 1'b0;
            while (pending_outcomes.size() != 0)
                @(posedge clk);
        end

        repeat (8) @(posedge clk);
        if (faults == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
dv/tb.sv
